// ===== rtl/icpr_pkg.sv =====
package icpr_pkg;

    // frame length limit and counter width
    localparam int MAX_FRAME_BYTES = 1024;
    localparam int CNT_W           = $clog2(MAX_FRAME_BYTES + 1);

    // datagram layout
    localparam int MIN_DATAGRAM     = 28;
    localparam int MIN_HEADER_WORDS = 5;
    localparam int ICMP_HDR_BYTES   = 8;
    localparam int QUOTED_PROTO_OFS = 9;

    // protocol and message codes
    localparam logic [7:0] PROTO_UDP          = 8'd17;
    localparam logic [7:0] TYPE_TIME_EXCEEDED = 8'd11;
    localparam logic [7:0] CODE_IN_TRANSIT    = 8'd0;
    localparam logic [7:0] TYPE_UNREACHABLE   = 8'd3;

    // configuration register map
    localparam int          ADDR_W       = 3;
    localparam logic        REG_SRC_PORT = 1'b0;
    localparam logic        REG_DST_PORT = 1'b1;

    typedef enum logic [2:0] {
        VERDICT_NO_MATCH = 3'd0,
        VERDICT_TTL      = 3'd1,
        VERDICT_UNREACH  = 3'd2,
        VERDICT_SHORT    = 3'd3,
        VERDICT_BAD_HDR  = 3'd4
    } verdict_t;

endpackage

// ===== rtl/icpr_if.sv =====
// byte stream of a received datagram
interface icpr_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] packet_byte;
    logic       last_byte;

    modport source (output valid, output packet_byte, output last_byte, input ready);
    modport sink   (input valid, input packet_byte, input last_byte, output ready);
endinterface

// one verdict per datagram
interface icpr_verdict_if;
    logic              valid;
    logic              ready;
    icpr_pkg::verdict_t verdict;

    modport source (output valid, output verdict, input ready);
    modport sink   (input valid, input verdict, output ready);
endinterface

// ===== rtl/icmp_probe_reply_classifier_top.sv =====
// channel   | dir | payload                   | handshake
// ----------+-----+---------------------------+-------------------------
// packet    | in  | packet_byte[7:0], last_byte | valid / ready
// result    | out | verdict[2:0]              | valid / ready
// apb       | in  | pwdata[31:0] @ paddr[2:0] | psel, penable, pready=1
//
// one byte per cycle unless a last byte waits on a stalled result; a byte
// is registered, then captured and classified, and a datagram's verdict is
// registered. rst_n clears all frame state and both probe ports. a stalled
// result holds in the output register while bytes of the next datagram
// keep flowing until a second verdict is due.
module icmp_probe_reply_classifier_top (
    input  logic                        clk,
    input  logic                        rst_n,
    icpr_byte_if.sink                   packet,
    icpr_verdict_if.source              result,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [icpr_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import icpr_pkg::*;

    // configuration
    logic [15:0] src_port_reg, src_port_next;
    logic [15:0] dst_port_reg, dst_port_next;

    // input register
    logic        in_valid_reg, in_valid_next;
    logic [7:0]  byte_reg, byte_next;
    logic        last_reg, last_next;

    // frame state
    logic [CNT_W-1:0] count_reg, count_next;
    logic [3:0]       outer_reg, outer_next;
    logic [3:0]       inner_reg, inner_next;
    logic [7:0]       type_reg, type_next;
    logic [7:0]       code_reg, code_next;
    logic [7:0]       proto_reg, proto_next;
    logic [15:0]      qsrc_reg, qsrc_next;
    logic [15:0]      qdst_reg, qdst_next;

    // output register
    logic        out_valid_reg, out_valid_next;
    verdict_t    verdict_reg, verdict_next;

    // working signals
    logic             cfg_write;
    logic             go;
    logic             in_accept;
    logic             take;
    logic [CNT_W-1:0] pos;
    logic [3:0]       outer_cur;
    logic [3:0]       inner_cur;
    logic [CNT_W-1:0] ol;
    logic [CNT_W-1:0] il;
    logic [CNT_W-1:0] u;
    logic [CNT_W-1:0] count_upd;
    logic [7:0]       type_upd, code_upd, proto_upd;
    logic [15:0]      qsrc_upd, qdst_upd;
    logic             match;
    verdict_t         verdict_calc;

    // apb port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == REG_DST_PORT) ? {16'd0, dst_port_reg}
                                                  : {16'd0, src_port_reg};

    always_comb
    begin
        src_port_next = src_port_reg;
        dst_port_next = dst_port_reg;
        if (cfg_write)
        begin
            case (paddr[2])
                REG_SRC_PORT: src_port_next = pwdata[15:0];
                REG_DST_PORT: dst_port_next = pwdata[15:0];
                default:      src_port_next = src_port_reg;
            endcase
        end
    end

    // flow control: hold only a last byte whose verdict has no room
    assign go        = in_valid_reg && (!last_reg || !out_valid_reg || result.ready);
    assign packet.ready = !in_valid_reg || go;
    assign in_accept = packet.valid && packet.ready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        byte_next     = byte_reg;
        last_next     = last_reg;
        if (in_accept)
        begin
            in_valid_next = 1'b1;
            byte_next     = packet.packet_byte;
            last_next     = packet.last_byte;
        end
        else if (go)
        begin
            in_valid_next = 1'b0;
        end
    end

    // field capture at header-relative offsets
    assign pos       = count_reg;
    assign take      = count_reg < CNT_W'(MAX_FRAME_BYTES);
    assign outer_cur = (take && pos == '0) ? byte_reg[3:0] : outer_reg;
    assign ol        = CNT_W'({outer_cur, 2'b00});
    assign inner_cur = (take && pos == ol + CNT_W'(ICMP_HDR_BYTES)) ? byte_reg[3:0]
                                                                     : inner_reg;
    assign il        = CNT_W'({inner_cur, 2'b00});
    assign u         = ol + CNT_W'(ICMP_HDR_BYTES) + il;

    always_comb
    begin
        count_upd = take ? count_reg + CNT_W'(1) : count_reg;
        type_upd  = (take && pos == ol) ? byte_reg : type_reg;
        code_upd  = (take && pos == ol + CNT_W'(1)) ? byte_reg : code_reg;
        proto_upd = (take && pos == ol + CNT_W'(ICMP_HDR_BYTES + QUOTED_PROTO_OFS))
                    ? byte_reg : proto_reg;
        qsrc_upd  = qsrc_reg;
        qdst_upd  = qdst_reg;
        if (take && pos == u)
            qsrc_upd[15:8] = byte_reg;
        if (take && pos == u + CNT_W'(1))
            qsrc_upd[7:0] = byte_reg;
        if (take && pos == u + CNT_W'(2))
            qdst_upd[15:8] = byte_reg;
        if (take && pos == u + CNT_W'(3))
            qdst_upd[7:0] = byte_reg;
    end

    // verdict from the updated frame state
    assign match = (proto_upd == PROTO_UDP) && (qsrc_upd == src_port_reg)
                   && (qdst_upd == dst_port_reg);

    always_comb
    begin
        if (count_upd < CNT_W'(MIN_DATAGRAM))
            verdict_calc = VERDICT_SHORT;
        else if (outer_cur < 4'(MIN_HEADER_WORDS))
            verdict_calc = VERDICT_BAD_HDR;
        else if (match && type_upd == TYPE_TIME_EXCEEDED && code_upd == CODE_IN_TRANSIT)
            verdict_calc = VERDICT_TTL;
        else if (match && type_upd == TYPE_UNREACHABLE)
            verdict_calc = VERDICT_UNREACH;
        else
            verdict_calc = VERDICT_NO_MATCH;
    end

    // frame state update, cleared after each verdict
    always_comb
    begin
        count_next = count_reg;
        outer_next = outer_reg;
        inner_next = inner_reg;
        type_next  = type_reg;
        code_next  = code_reg;
        proto_next = proto_reg;
        qsrc_next  = qsrc_reg;
        qdst_next  = qdst_reg;
        if (go && last_reg)
        begin
            count_next = '0;
            outer_next = '0;
            inner_next = '0;
            type_next  = '0;
            code_next  = '0;
            proto_next = '0;
            qsrc_next  = '0;
            qdst_next  = '0;
        end
        else if (go)
        begin
            count_next = count_upd;
            outer_next = outer_cur;
            inner_next = inner_cur;
            type_next  = type_upd;
            code_next  = code_upd;
            proto_next = proto_upd;
            qsrc_next  = qsrc_upd;
            qdst_next  = qdst_upd;
        end
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        verdict_next   = verdict_reg;
        if (go && last_reg)
        begin
            out_valid_next = 1'b1;
            verdict_next   = verdict_calc;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign result.valid   = out_valid_reg;
    assign result.verdict = verdict_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_port_reg  <= '0;
            dst_port_reg  <= '0;
            in_valid_reg  <= 1'b0;
            byte_reg      <= '0;
            last_reg      <= 1'b0;
            count_reg     <= '0;
            outer_reg     <= '0;
            inner_reg     <= '0;
            type_reg      <= '0;
            code_reg      <= '0;
            proto_reg     <= '0;
            qsrc_reg      <= '0;
            qdst_reg      <= '0;
            out_valid_reg <= 1'b0;
            verdict_reg   <= VERDICT_NO_MATCH;
        end
        else
        begin
            src_port_reg  <= src_port_next;
            dst_port_reg  <= dst_port_next;
            in_valid_reg  <= in_valid_next;
            byte_reg      <= byte_next;
            last_reg      <= last_next;
            count_reg     <= count_next;
            outer_reg     <= outer_next;
            inner_reg     <= inner_next;
            type_reg      <= type_next;
            code_reg      <= code_next;
            proto_reg     <= proto_next;
            qsrc_reg      <= qsrc_next;
            qdst_reg      <= qdst_next;
            out_valid_reg <= out_valid_next;
            verdict_reg   <= verdict_next;
        end
    end

endmodule

// ===== rtl/icpr_checker.sv =====
module icpr_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        packet_ready,
    input logic                        result_valid,
    input logic                        result_ready,
    input logic [2:0]                  result_verdict,
    input logic                        psel,
    input logic                        penable,
    input logic                        pwrite,
    input logic [icpr_pkg::ADDR_W-1:0] paddr,
    input logic [31:0]                 pwdata,
    input logic [31:0]                 prdata
);
    import icpr_pkg::*;

    // stalled verdict holds
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result_verdict))
        else $error("verdict changed while stalled");

    // verdict code stays in the defined set
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result_verdict <= 3'(VERDICT_BAD_HDR))
        else $error("undefined verdict code");

    // an empty output register never stalls the byte stream
    assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid |-> packet_ready)
        else $error("byte stream stalled with no verdict pending");

    // written probe port reads back, upper bits zero
    assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite
        |=> !(psel && !pwrite && paddr[2] == $past(paddr[2]))
            || prdata == {16'd0, $past(pwdata[15:0])})
        else $error("probe port readback mismatch");

endmodule

bind icmp_probe_reply_classifier_top icpr_checker u_icpr_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .packet_ready   (packet.ready),
    .result_valid   (result.valid),
    .result_ready   (result.ready),
    .result_verdict (result.verdict),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata)
);

// ===== bench/icmp_probe_reply_classifier_top_tb.sv =====
`timescale 1ns / 100ps

module icmp_probe_reply_classifier_top_tb;
    import icpr_pkg::*;

    // message and protocol codes used beside the package ones
    localparam logic [7:0] TYPE_ECHO_REPLY      = 8'd0;
    localparam logic [7:0] CODE_FRAG_REASSEMBLY = 8'd1;
    localparam logic [7:0] CODE_PORT_UNREACH    = 8'd3;
    localparam logic [7:0] PROTO_TCP            = 8'd6;

    // one directed datagram: header fields, fill and optional typed verdict
    typedef struct {
        int unsigned len;
        logic [3:0]  outer_ihl;
        logic [7:0]  msg_type;
        logic [7:0]  msg_code;
        logic [3:0]  inner_ihl;
        logic [7:0]  proto;
        logic [15:0] src_flip;
        logic [15:0] dst_flip;
        bit          rand_fill;
        logic [7:0]  fill;
        bit          typed;
        verdict_t    verdict;
    } frame_spec_t;

    // fields captured from the datagram so far
    typedef struct {
        int unsigned count;
        logic [3:0]  outer_words;
        logic [3:0]  inner_words;
        logic [7:0]  msg_type;
        logic [7:0]  msg_code;
        logic [7:0]  proto;
        logic [15:0] src_port;
        logic [15:0] dst_port;
    } reply_fields_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    icpr_byte_if    pkt_if ();
    icpr_verdict_if verdict_if ();

    icmp_probe_reply_classifier_top dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .packet  (pkt_if),
        .result  (verdict_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    reply_fields_t held;
    logic [15:0]   cfg_src;
    logic [15:0]   cfg_dst;
    logic [7:0]    frame_bytes [$];
    verdict_t      verdict_queue [$];
    int            failures;
    int unsigned   hold_off_cycles;
    bit            tx_burst;
    bit            rx_burst;

    frame_spec_t directed_frames [19] = '{
        '{1, 4'd5, TYPE_TIME_EXCEEDED, CODE_IN_TRANSIT, 4'd5, PROTO_UDP, 16'h0, 16'h0,
          1'b0, 8'h45, 1'b1, VERDICT_SHORT},
        '{27, 4'd5, TYPE_TIME_EXCEEDED, CODE_IN_TRANSIT, 4'd5, PROTO_UDP, 16'h0, 16'h0,
          1'b1, 8'h00, 1'b1, VERDICT_SHORT},
        '{27, 4'd0, TYPE_TIME_EXCEEDED, CODE_IN_TRANSIT, 4'd5, PROTO_UDP, 16'h0, 16'h0,
          1'b1, 8'h00, 1'b1, VERDICT_SHORT},
        '{28, 4'd4, TYPE_TIME_EXCEEDED, CODE_IN_TRANSIT, 4'd5, PROTO_UDP, 16'h0, 16'h0,
          1'b1, 8'h00, 1'b1, VERDICT_BAD_HDR},
        '{28, 4'd0, TYPE_ECHO_REPLY, CODE_IN_TRANSIT, 4'd0, 8'h00, 16'h0, 16'h0,
          1'b0, 8'h00, 1'b1, VERDICT_BAD_HDR},
        '{44, 4'd0, TYPE_TIME_EXCEEDED, CODE_IN_TRANSIT, 4'd5, PROTO_UDP, 16'h0, 16'h0,
          1'b1, 8'h00, 1'b0, VERDICT_NO_MATCH},
        '{48, 4'd1, TYPE_UNREACHABLE, CODE_PORT_UNREACH, 4'd0, PROTO_UDP, 16'h0, 16'h0,
          1'b1, 8'h00, 1'b0, VERDICT_NO_MATCH},
        '{48, 4'd2, TYPE_TIME_EXCEEDED, CODE_IN_TRANSIT, 4'd1, PROTO_UDP, 16'h0, 16'h0,
          1'b1, 8'h00, 1'b0, VERDICT_NO_MATCH},
        '{56, 4'd5, TYPE_TIME_EXCEEDED, CODE_IN_TRANSIT, 4'd5, PROTO_UDP, 16'h0, 16'h0,
          1'b1, 8'h00, 1'b1, VERDICT_TTL},
        '{60, 4'd5, TYPE_UNREACHABLE, CODE_PORT_UNREACH, 4'd5, PROTO_UDP, 16'h0, 16'h0,
          1'b1, 8'h00, 1'b1, VERDICT_UNREACH},
        '{56, 4'd5, TYPE_TIME_EXCEEDED, CODE_FRAG_REASSEMBLY, 4'd5, PROTO_UDP, 16'h0, 16'h0,
          1'b1, 8'h00, 1'b1, VERDICT_NO_MATCH},
        '{56, 4'd5, TYPE_ECHO_REPLY, CODE_IN_TRANSIT, 4'd5, PROTO_UDP, 16'h0, 16'h0,
          1'b1, 8'h00, 1'b1, VERDICT_NO_MATCH},
        '{56, 4'd5, TYPE_TIME_EXCEEDED, CODE_IN_TRANSIT, 4'd5, PROTO_TCP, 16'h0, 16'h0,
          1'b1, 8'h00, 1'b1, VERDICT_NO_MATCH},
        '{56, 4'd5, TYPE_TIME_EXCEEDED, CODE_IN_TRANSIT, 4'd5, PROTO_UDP, 16'h0001, 16'h0,
          1'b1, 8'h00, 1'b1, VERDICT_NO_MATCH},
        '{56, 4'd5, TYPE_UNREACHABLE, CODE_PORT_UNREACH, 4'd5, PROTO_UDP, 16'h0, 16'h8000,
          1'b1, 8'h00, 1'b1, VERDICT_NO_MATCH},
        '{30, 4'd5, TYPE_TIME_EXCEEDED, CODE_IN_TRANSIT, 4'd5, PROTO_UDP, 16'h0, 16'h0,
          1'b1, 8'h00, 1'b1, VERDICT_NO_MATCH},
        '{39, 4'd5, TYPE_TIME_EXCEEDED, CODE_IN_TRANSIT, 4'd5, PROTO_UDP, 16'h0, 16'h0,
          1'b1, 8'h00, 1'b0, VERDICT_NO_MATCH},
        '{132, 4'd15, TYPE_UNREACHABLE, CODE_PORT_UNREACH, 4'd15, PROTO_UDP, 16'h0, 16'h0,
          1'b1, 8'h00, 1'b0, VERDICT_NO_MATCH},
        '{200, 4'd15, 8'hFF, 8'hFF, 4'd15, 8'hFF, 16'hFFFF, 16'hFFFF,
          1'b0, 8'hFF, 1'b1, VERDICT_NO_MATCH}
    };

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // run limit
    initial
    begin
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // take one byte into the captured fields, give the verdict on the last byte
    function automatic bit classify_byte(input logic [7:0] b, input bit last,
                                         output verdict_t v);
        int unsigned pos;
        int unsigned ol;
        int unsigned il;
        int unsigned u;
        v = VERDICT_NO_MATCH;
        if (held.count < MAX_FRAME_BYTES)
        begin
            pos = held.count;
            if (pos == 0)
                held.outer_words = b[3:0];
            ol = held.outer_words * 4;
            if (pos == ol)
                held.msg_type = b;
            if (pos == ol + 1)
                held.msg_code = b;
            if (pos == ol + ICMP_HDR_BYTES)
                held.inner_words = b[3:0];
            il = held.inner_words * 4;
            if (pos == ol + ICMP_HDR_BYTES + QUOTED_PROTO_OFS)
                held.proto = b;
            u = ol + ICMP_HDR_BYTES + il;
            if (pos == u)
                held.src_port[15:8] = b;
            if (pos == u + 1)
                held.src_port[7:0] = b;
            if (pos == u + 2)
                held.dst_port[15:8] = b;
            if (pos == u + 3)
                held.dst_port[7:0] = b;
            held.count++;
        end
        if (!last)
            return 1'b0;
        // too short beats bad header, bad header beats the match test
        if (held.count < MIN_DATAGRAM)
            v = VERDICT_SHORT;
        else if (held.outer_words < MIN_HEADER_WORDS)
            v = VERDICT_BAD_HDR;
        else if (held.proto == PROTO_UDP && held.src_port == cfg_src &&
                 held.dst_port == cfg_dst)
        begin
            if (held.msg_type == TYPE_TIME_EXCEEDED && held.msg_code == CODE_IN_TRANSIT)
                v = VERDICT_TTL;
            else if (held.msg_type == TYPE_UNREACHABLE)
                v = VERDICT_UNREACH;
        end
        held = '{default: 0};
        return 1'b1;
    endfunction

    function automatic void place(int unsigned pos, logic [7:0] b);
        if (pos < frame_bytes.size())
            frame_bytes[pos] = b;
    endfunction

    // lay out a datagram in the same field order the block captures
    function automatic void build_frame(int unsigned len, logic [3:0] oihl,
                                        logic [7:0] mtype, logic [7:0] mcode,
                                        logic [3:0] iihl, logic [7:0] proto,
                                        logic [15:0] sport, logic [15:0] dport,
                                        bit rand_fill, logic [7:0] fill);
        int unsigned ol;
        int unsigned u;
        frame_bytes.delete();
        for (int unsigned i = 0; i < len; i++)
            frame_bytes.push_back(rand_fill ? 8'($urandom) : fill);
        ol = oihl * 4;
        u  = ol + ICMP_HDR_BYTES + iihl * 4;
        place(0, {4'h4, oihl});
        place(ol, mtype);
        place(ol + 1, mcode);
        place(ol + ICMP_HDR_BYTES, {4'h4, iihl});
        place(ol + ICMP_HDR_BYTES + QUOTED_PROTO_OFS, proto);
        place(u, sport[15:8]);
        place(u + 1, sport[7:0]);
        place(u + 2, dport[15:8]);
        place(u + 3, dport[7:0]);
    endfunction

    // mostly well-formed replies, with short, truncated, tiny-header and noise ones
    function automatic void random_frame();
        int unsigned pick;
        int unsigned len;
        int unsigned oihl;
        int unsigned iihl;
        int unsigned ports_end;
        logic [7:0]  mtype;
        logic [7:0]  mcode;
        logic [7:0]  proto;
        logic [15:0] sport;
        logic [15:0] dport;
        pick = $urandom_range(0, 99);
        oihl = ($urandom_range(0, 3) == 0) ? $urandom_range(6, 15) : 5;
        iihl = ($urandom_range(0, 3) == 0) ? $urandom_range(6, 15) : 5;
        case ($urandom_range(0, 3))
            0, 1:    mtype = TYPE_TIME_EXCEEDED;
            2:       mtype = TYPE_UNREACHABLE;
            default: mtype = 8'($urandom);
        endcase
        mcode = ($urandom_range(0, 3) != 0) ? CODE_IN_TRANSIT : 8'($urandom);
        proto = ($urandom_range(0, 9) != 0) ? PROTO_UDP : 8'($urandom);
        sport = cfg_src;
        dport = cfg_dst;
        if ($urandom_range(0, 4) == 0)
            sport ^= 16'(1 << $urandom_range(0, 15));
        if ($urandom_range(0, 4) == 0)
            dport ^= 16'(1 << $urandom_range(0, 15));
        ports_end = oihl * 4 + ICMP_HDR_BYTES + iihl * 4 + 4;
        len = ports_end + $urandom_range(0, 12);
        if (pick < 14)
            len = $urandom_range(ports_end - 3, ports_end - 1);
        else if (pick < 28)
            len = $urandom_range(1, MIN_DATAGRAM - 1);
        else if (pick < 38)
        begin
            oihl = $urandom_range(0, MIN_HEADER_WORDS - 1);
            len  = $urandom_range(MIN_DATAGRAM, 60);
        end
        else if (pick < 46)
            len = $urandom_range(1, 80);
        build_frame(len, 4'(oihl), mtype, mcode, 4'(iihl), proto, sport, dport, 1'b1, 8'h00);
        // noise: no structure at all
        if (pick >= 38 && pick < 46)
            foreach (frame_bytes[i])
                frame_bytes[i] = 8'($urandom);
    endfunction

    // offer the built datagram byte by byte, predicting on each accepted item
    task automatic send_frame(bit typed, verdict_t typed_v);
        int unsigned gap;
        bit          is_last;
        verdict_t    v;
        foreach (frame_bytes[i])
        begin
            gap = tx_burst ? 0 : $urandom_range(0, 8);
            is_last = (i == frame_bytes.size() - 1);
            if (gap > 0)
            begin
                pkt_if.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            pkt_if.valid       <= 1'b1;
            pkt_if.packet_byte <= frame_bytes[i];
            pkt_if.last_byte   <= is_last;
            do
                @(posedge clk);
            while (!pkt_if.ready);
            if (classify_byte(frame_bytes[i], is_last, v))
                verdict_queue.push_back(typed ? typed_v : v);
            @(negedge clk);
        end
    endtask

    // stop offering and wait for every verdict, then let the pipeline settle
    task automatic wait_drained();
        pkt_if.valid <= 1'b0;
        while (verdict_queue.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        @(negedge clk);
    endtask

    // apb write of one probe port register
    task automatic write_port_reg(logic idx, logic [15:0] port);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'($urandom), port};
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (idx == REG_SRC_PORT)
            cfg_src = port;
        else
            cfg_dst = port;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // verdict sink with random stalls and one long hold-off on request
    initial
    begin
        int unsigned stall;
        verdict_if.ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if ($urandom_range(0, 15) == 0)
                rx_burst = !rx_burst;
            stall = rx_burst ? 0 : $urandom_range(0, 8);
            if (hold_off_cycles != 0)
            begin
                stall = hold_off_cycles;
                hold_off_cycles = 0;
            end
            if (stall > 0)
            begin
                verdict_if.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            verdict_if.ready <= 1'b1;
            do
                @(posedge clk);
            while (!verdict_if.valid);
            @(negedge clk);
        end
    end

    // compare each accepted verdict with the oldest prediction
    always @(posedge clk)
    begin
        verdict_t exp_v;
        if (rst_n && verdict_if.valid && verdict_if.ready)
        begin
            if (verdict_queue.size() == 0)
            begin
                $error("verdict: expected none, actual %0d", verdict_if.verdict);
                failures++;
            end
            else
            begin
                exp_v = verdict_queue.pop_front();
                if (verdict_if.verdict !== exp_v)
                begin
                    $error("verdict: expected %0d, actual %0d", exp_v, verdict_if.verdict);
                    failures++;
                end
            end
        end
    end

    // reset, directed datagrams, then random phases over several port settings
    initial
    begin
        logic [15:0] phase_src [4];
        logic [15:0] phase_dst [4];
        logic [15:0] src;
        logic [15:0] dst;
        int unsigned phase_bytes;
        frame_spec_t r;

        phase_src          = '{16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF};
        phase_dst          = '{16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000};
        rst_n              = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        pkt_if.valid       = 1'b0;
        pkt_if.packet_byte = '0;
        pkt_if.last_byte   = 1'b0;
        failures           = 0;
        hold_off_cycles    = 0;
        tx_burst           = 1'b0;
        rx_burst           = 1'b0;
        cfg_src            = '0;
        cfg_dst            = '0;
        held               = '{default: 0};
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed table
        write_port_reg(REG_SRC_PORT, 16'h829B);
        write_port_reg(REG_DST_PORT, 16'h8A5D);
        foreach (directed_frames[i])
        begin
            r = directed_frames[i];
            build_frame(r.len, r.outer_ihl, r.msg_type, r.msg_code, r.inner_ihl, r.proto,
                        cfg_src ^ r.src_flip, cfg_dst ^ r.dst_flip, r.rand_fill, r.fill);
            send_frame(r.typed, r.verdict);
        end
        wait_drained();

        // random phases, port registers changed only while idle
        for (int ph = 0; ph < 6; ph++)
        begin
            src = (ph < 4) ? phase_src[ph] : 16'($urandom);
            dst = (ph < 4) ? phase_dst[ph] : 16'($urandom);
            write_port_reg(REG_SRC_PORT, src);
            write_port_reg(REG_DST_PORT, dst);
            phase_bytes = 0;
            while (phase_bytes < 40)
            begin
                if ($urandom_range(0, 4) == 0)
                    tx_burst = !tx_burst;
                random_frame();
                phase_bytes += frame_bytes.size();
                send_frame(1'b0, VERDICT_NO_MATCH);
            end
            // long sink hold-off with back-to-back short replies, then a full pause
            if (ph == 2)
            begin
                hold_off_cycles = 300;
                tx_burst = 1'b1;
                repeat (6)
                begin
                    build_frame($urandom_range(MIN_DATAGRAM, 34), 4'd5, TYPE_UNREACHABLE,
                                CODE_PORT_UNREACH, 4'd5, PROTO_UDP, cfg_src, cfg_dst,
                                1'b1, 8'h00);
                    send_frame(1'b0, VERDICT_NO_MATCH);
                end
                tx_burst = 1'b0;
            end
            wait_drained();
        end

        repeat (8) @(posedge clk);
        if (failures == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
